// ===== rtl/lstt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstt_pkg
// Types and codes shared by the link state table tracker.
// ----------------------------------------------------------------------------
package lstt_pkg;

   typedef enum logic [2:0] {
      OP_OBSERVE      = 3'd0,
      OP_GONE         = 3'd1,
      OP_HEARD        = 3'd2,
      OP_SERVE_FAILED = 3'd3,
      OP_TICK         = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      MODE_ABSENT  = 3'd0,
      MODE_DOWN    = 3'd1,
      MODE_LINKED  = 3'd2,
      MODE_SEGMENT = 3'd3,
      MODE_HOLD    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      VERB_LISTEN   = 3'd0,
      VERB_UNLISTEN = 3'd1,
      VERB_SERVE    = 3'd2,
      VERB_DROP     = 3'd3,
      VERB_KEPT     = 3'd4
   } verb_type;

   localparam logic CSR_HOLD_TIME  = 1'b0;
   localparam logic CSR_RETRY_TIME = 1'b1;

   localparam int RESULT_LIMIT = 16;
   localparam logic [39:0] TIME_RESET = 40'd1000000000;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] name_tag;
      logic [30:0] if_index;
      logic        is_ether;
      logic        carrier_up;
      logic [63:0] now_ns;
   } req_type;

   typedef struct packed {
      logic [2:0]  verb;
      logic [31:0] event_tag;
      logic [15:0] flap_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] key;
      logic [30:0] ifindex;
      logic [63:0] hold_dl;
      logic [63:0] retry_dl;
      logic [15:0] flaps;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_ACT,
      ST_EMIT,
      ST_ALLOC_RD,
      ST_ALLOC,
      ST_TICK_RD,
      ST_TICK,
      ST_WAIT
   } state_type;

endpackage

// ===== rtl/lstt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstt_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface lstt_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/link_state_table_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_state_table_tracker_top
// Port table tracker: link mode per named port, emits link events.
// ----------------------------------------------------------------------------
// One request at a time. The table sits in a single-port-read memory, so a
// request walks the entries one by one, each read registered before it is
// checked; a lookup may go on into an allocation walk, and a tick walk emits its
// events as it goes. Each event waits in the output register until taken,
// while the walk stalls. A tick drop is held back until the walk shows whether
// another one follows, so its last flag is settled before it is offered.
module link_state_table_tracker_top
   import lstt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic clock,
   input  logic reset,
   lstt_if.sink   req,
   lstt_if.source rsp,
   lstt_if.sink   csr
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [39:0] hold_t_ff, retry_t_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0]  cnt_ff, cnt_in;
   entry_type   ent_ff, ent_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic        alloc_ff, alloc_in;
   rsp_type     out_ff, out_in;
   logic        ovld_ff, ovld_in;
   logic        pend_ff, pend_in;

   entry_type   rd_data, wr_data;
   logic        wr_en;
   logic [AW-1:0] rd_addr;

   req_type     req_d;
   rsp_type     rsp_d;
   assign req_d = req_type'(req.data);
   assign rsp.data = rsp_d;
   assign rsp_d = out_ff;
   assign rsp.valid = ovld_ff;
   assign req.ready = (state_ff == ST_IDLE) && !ovld_ff;
   assign csr.ready = 1'b1;

   lstt_mem #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_mem (
      .clock, .reset, .rd_addr, .rd_data,
      .wr_en, .wr_addr(slot_ff), .wr_data
   );

   assign rd_addr = idx_ff[AW-1:0];

   logic out_free;
   assign out_free = !ovld_ff || rsp.ready;
   logic [63:0] hold_dl_new, retry_dl_new;
   assign hold_dl_new  = req_ff.now_ns + {24'd0, hold_t_ff};
   assign retry_dl_new = req_ff.now_ns + {24'd0, retry_t_ff};
   logic is_last_idx;
   assign is_last_idx = (idx_ff == CW'(TABLE_ENTRIES - 1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      ent_in   = ent_ff;
      slot_in  = slot_ff;
      alloc_in = alloc_ff;
      out_in   = out_ff;
      ovld_in  = ovld_ff && !rsp.ready;
      pend_in  = pend_ff;
      wr_en    = 1'b0;
      wr_data  = ent_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               idx_in = '0;
               cnt_in = '0;
               alloc_in = 1'b0;
               if (req_d.op == OP_TICK) begin
                  state_in = ST_TICK_RD;
               end else if (req_d.op <= OP_SERVE_FAILED && req_d.name_tag != '0) begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN;
         ST_SCAN: begin
            if (rd_data.mode != MODE_ABSENT && rd_data.key == req_ff.name_tag) begin
               ent_in = rd_data;
               slot_in = idx_ff[AW-1:0];
               state_in = ST_ACT;
            end else if (is_last_idx) begin
               if (req_ff.op == OP_OBSERVE && req_ff.is_ether) begin
                  idx_in = '0;
                  state_in = ST_ALLOC_RD;
               end else begin
                  state_in = ST_WAIT;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_ALLOC_RD: state_in = ST_ALLOC;
         ST_ALLOC: begin
            if (rd_data.mode == MODE_ABSENT) begin
               slot_in = idx_ff[AW-1:0];
               ent_in = '0;
               ent_in.mode = MODE_DOWN;
               ent_in.key = req_ff.name_tag;
               ent_in.ifindex = req_ff.if_index;
               alloc_in = 1'b1;
               state_in = ST_ACT;
            end else if (is_last_idx) begin
               state_in = ST_WAIT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_ALLOC_RD;
            end
         end
         ST_ACT: begin
            if (out_free) begin
               state_in = ST_WAIT;
               out_in.event_tag = ent_ff.key;
               out_in.flap_total = ent_ff.flaps;
               out_in.last = 1'b1;
               wr_en = 1'b1;
               wr_data = ent_ff;
               if ((req_ff.op == OP_OBSERVE && !req_ff.is_ether && !alloc_ff)
                   || (req_ff.op == OP_GONE
                       && (req_ff.if_index == '0 || ent_ff.ifindex == req_ff.if_index))
                   || (req_ff.op == OP_OBSERVE && !alloc_ff
                       && ent_ff.ifindex != req_ff.if_index)) begin
                  wr_data = '0;
                  ovld_in = (ent_ff.mode != MODE_DOWN);
                  out_in.verb = (ent_ff.mode == MODE_LINKED) ? VERB_UNLISTEN : VERB_DROP;
                  if (req_ff.op == OP_OBSERVE && req_ff.is_ether) begin
                     // the new entry starts down: it only reports if carrier is up
                     out_in.last = !req_ff.carrier_up;
                     idx_in = '0;
                     state_in = ST_ALLOC_RD;
                  end
               end else if (req_ff.op == OP_OBSERVE) begin
                  case (ent_ff.mode)
                     MODE_DOWN: begin
                        if (req_ff.carrier_up) begin
                           wr_data.mode = MODE_LINKED;
                           wr_data.retry_dl = '0;
                           out_in.verb = VERB_LISTEN;
                           ovld_in = 1'b1;
                        end
                     end
                     MODE_LINKED: begin
                        if (!req_ff.carrier_up) begin
                           wr_data.mode = MODE_DOWN;
                           out_in.verb = VERB_UNLISTEN;
                           ovld_in = 1'b1;
                        end
                     end
                     MODE_SEGMENT: begin
                        if (!req_ff.carrier_up) begin
                           wr_data.mode = MODE_HOLD;
                           wr_data.hold_dl = hold_dl_new;
                        end
                     end
                     MODE_HOLD: begin
                        if (req_ff.carrier_up) begin
                           wr_data.mode = MODE_SEGMENT;
                           wr_data.hold_dl = '0;
                           if (ent_ff.flaps != 16'hFFFF) begin
                              wr_data.flaps = ent_ff.flaps + 16'd1;
                           end
                           out_in.flap_total = wr_data.flaps;
                           out_in.verb = VERB_KEPT;
                           ovld_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end else if (req_ff.op == OP_HEARD) begin
                  if (ent_ff.mode == MODE_LINKED && (ent_ff.retry_dl == '0
                      || req_ff.now_ns >= ent_ff.retry_dl)) begin
                     wr_data.mode = MODE_SEGMENT;
                     wr_data.retry_dl = '0;
                     out_in.verb = VERB_SERVE;
                     ovld_in = 1'b1;
                  end
               end else if (req_ff.op == OP_SERVE_FAILED) begin
                  if (ent_ff.mode == MODE_SEGMENT || ent_ff.mode == MODE_HOLD) begin
                     wr_data.mode = (ent_ff.mode == MODE_SEGMENT) ? MODE_LINKED : MODE_DOWN;
                     wr_data.hold_dl = '0;
                     wr_data.retry_dl = retry_dl_new;
                     out_in.verb = VERB_LISTEN;
                     ovld_in = (ent_ff.mode == MODE_SEGMENT);
                  end
               end
            end
         end
         ST_TICK_RD: state_in = ST_TICK;
         ST_TICK: begin
            if (rd_data.mode == MODE_HOLD && req_ff.now_ns >= rd_data.hold_dl) begin
               slot_in = idx_ff[AW-1:0];
               ent_in = rd_data;
               ent_in.mode = MODE_DOWN;
               ent_in.hold_dl = '0;
               state_in = ST_EMIT;
               if (pend_ff) begin
                  ovld_in = 1'b1;
                  pend_in = 1'b0;
               end
            end else if (is_last_idx) begin
               state_in = ST_WAIT;
               if (pend_ff) begin
                  out_in.last = 1'b1;
                  ovld_in = 1'b1;
                  pend_in = 1'b0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_TICK_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               wr_en = 1'b1;
               wr_data = ent_ff;
               cnt_in = cnt_ff + 5'd1;
               out_in.verb = VERB_DROP;
               out_in.event_tag = ent_ff.key;
               out_in.flap_total = ent_ff.flaps;
               out_in.last = 1'b0;
               pend_in = 1'b1;
               if (is_last_idx || cnt_ff == 5'(RESULT_LIMIT - 1)) begin
                  out_in.last = 1'b1;
                  ovld_in = 1'b1;
                  pend_in = 1'b0;
                  state_in = ST_WAIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_TICK_RD;
               end
            end
         end
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovld_ff   <= 1'b0;
         hold_t_ff <= TIME_RESET;
         retry_t_ff <= TIME_RESET;
         pend_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         pend_ff  <= pend_in;
         if (csr.valid && csr.ready) begin
            if (csr.data[40] == CSR_HOLD_TIME) begin
               hold_t_ff <= csr.data[39:0];
            end else if (csr.data[40] == CSR_RETRY_TIME) begin
               retry_t_ff <= csr.data[39:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_ff <= req_d;
      end
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      ent_ff   <= ent_in;
      slot_ff  <= slot_in;
      alloc_ff <= alloc_in;
      out_ff   <= out_in;
   end
endmodule

// ===== rtl/lstt_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstt_mem
// Entry store: one write port, one registered read port, valid bit per entry.
// ----------------------------------------------------------------------------
module lstt_mem
   import lstt_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int AW = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data
);
   entry_type              mem_ff [ENTRIES];
   logic [ENTRIES-1:0]     vld_ff;
   entry_type              data_ff;
   logic                   hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      rd_data = data_ff;
      if (!hit_ff) begin
         rd_data = '0;
      end
   end
endmodule
